FILE: src/serial_modem_mode_shifter_core_defines.svh
// Assertion macros used by the checker file of the mode shifter.
`ifndef SERIAL_MODEM_MODE_SHIFTER_CORE_DEFINES_SVH
`define SERIAL_MODEM_MODE_SHIFTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, idle in reset.
`define SMMS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, idle in reset.
`define SMMS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/smms_pkg.sv
// Types, codes and constants of the serial modem mode shifter.
package smms_pkg;

    localparam int TIME_W    = 48;
    localparam int GAP_W     = 20;
    localparam int BIT_W     = 18;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int NUM_WIN   = 4;

    // Line event codes; the fourth code carries no event.
    typedef enum logic [1:0] {
        FUNC_MOTOR   = 2'd0,
        FUNC_COMMAND = 2'd1,
        FUNC_BYTE    = 2'd2
    } func_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_GAP_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_GAP_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BIT_CYCLES = 2'd2;

    localparam logic [GAP_W-1:0] EDGE_GAP_MIN_RST   = 20'd44802;
    localparam logic [GAP_W-1:0] EDGE_GAP_MAX_RST   = 20'd119472;
    localparam logic [BIT_W-1:0] MIN_BIT_CYCLES_RST = 18'd3000;

    // Baud windows in priority order: 300, 210, 110, 500 baud.
    localparam logic [BIT_W-1:0] WIN_LO [NUM_WIN] = '{18'd5666, 18'd8096, 18'd15457, 18'd3401};
    localparam logic [BIT_W-1:0] WIN_HI [NUM_WIN] = '{18'd6265, 18'd8950, 18'd17085, 18'd3759};

    localparam logic [2:0] PHASE_COMMIT = 3'd7;

    typedef struct packed {
        logic [GAP_W-1:0] edge_gap_min;
        logic [GAP_W-1:0] edge_gap_max;
        logic [BIT_W-1:0] min_bit_cycles;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_edge_time;
        logic [2:0]        shift_phase;
        logic [3:0]        shift_bits;
        logic              comm_flag;
        logic              hook_flag;
        logic              answer_flag;
        logic              dial_flag;
        logic [1:0]        rate_index;
    } state_t;

    typedef struct packed {
        logic              forward_valid;
        logic [BYTE_W-1:0] forward_byte;
        logic [1:0]        rate_code;
        logic              comm_active;
        logic              off_hook;
        logic              answer_mode;
        logic              dial_mode;
        logic              do_answer;
        logic              do_hangup;
        logic              dial_timer_restart;
        logic              mode_committed;
    } result_t;

endpackage

FILE: src/smms_in_if.sv
// Input channel of line events.
interface smms_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  func;
    logic                        level;
    logic [smms_pkg::TIME_W-1:0] now;
    logic                        command_level;
    logic [smms_pkg::BYTE_W-1:0] data_byte;
    logic [smms_pkg::BIT_W-1:0]  cycles_per_bit;

    modport source (
        output valid, func, level, now, command_level, data_byte, cycles_per_bit,
        input  ready
    );
    modport sink (
        input  valid, func, level, now, command_level, data_byte, cycles_per_bit,
        output ready
    );
endinterface

FILE: src/smms_out_if.sv
// Output channel of result words.
interface smms_out_if;
    logic                        valid;
    logic                        ready;
    logic                        forward_valid;
    logic [smms_pkg::BYTE_W-1:0] forward_byte;
    logic [1:0]                  rate_code;
    logic                        comm_active;
    logic                        off_hook;
    logic                        answer_mode;
    logic                        dial_mode;
    logic                        do_answer;
    logic                        do_hangup;
    logic                        dial_timer_restart;
    logic                        mode_committed;

    modport source (
        output valid, forward_valid, forward_byte, rate_code, comm_active, off_hook,
               answer_mode, dial_mode, do_answer, do_hangup, dial_timer_restart,
               mode_committed,
        input  ready
    );
    modport sink (
        input  valid, forward_valid, forward_byte, rate_code, comm_active, off_hook,
               answer_mode, dial_mode, do_answer, do_hangup, dial_timer_restart,
               mode_committed,
        output ready
    );
endinterface

FILE: src/serial_modem_mode_shifter_core.sv
// Top level of the serial modem mode shifter.
//
//  channel  direction  handshake      word
//  req      in         valid/ready    line event: func, level, now, command, byte, period
//  rsp      out        valid/ready    status word with forwarded byte and pulses
//  cfg      in         cfg_we         register write: cfg_index, cfg_data
//
// One event is accepted per cycle while rsp is free or draining; its result word is
// loaded into the result register in the next cycle, set by the 48-bit gap subtract
// and window compares. A new event is taken while a word waits only if that word
// leaves the same cycle. Reset clears all state and the output valid and loads
// register defaults. A stalled rsp holds its word and blocks req until it is taken.
module serial_modem_mode_shifter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    smms_in_if.sink                          req,
    smms_out_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [smms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smms_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import smms_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t rsp_reg;
    result_t rsp_next;
    logic    rsp_valid_reg;
    logic    accept;

    // Take a word when the result register is free or draining
    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;

    smms_step u_step (
        .cfg            (cfg_reg),
        .cur            (state_reg),
        .func           (req.func),
        .level          (req.level),
        .now            (req.now),
        .command_level  (req.command_level),
        .data_byte      (req.data_byte),
        .cycles_per_bit (req.cycles_per_bit),
        .nxt            (state_next),
        .res            (rsp_next)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_gap_min   <= EDGE_GAP_MIN_RST;
            cfg_reg.edge_gap_max   <= EDGE_GAP_MAX_RST;
            cfg_reg.min_bit_cycles <= MIN_BIT_CYCLES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGE_GAP_MIN:   cfg_reg.edge_gap_min   <= cfg_data;
                CFG_EDGE_GAP_MAX:   cfg_reg.edge_gap_max   <= cfg_data;
                CFG_MIN_BIT_CYCLES: cfg_reg.min_bit_cycles <= cfg_data[BIT_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Advance state on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.forward_valid      = rsp_reg.forward_valid;
    assign rsp.forward_byte       = rsp_reg.forward_byte;
    assign rsp.rate_code          = rsp_reg.rate_code;
    assign rsp.comm_active        = rsp_reg.comm_active;
    assign rsp.off_hook           = rsp_reg.off_hook;
    assign rsp.answer_mode        = rsp_reg.answer_mode;
    assign rsp.dial_mode          = rsp_reg.dial_mode;
    assign rsp.do_answer          = rsp_reg.do_answer;
    assign rsp.do_hangup          = rsp_reg.do_hangup;
    assign rsp.dial_timer_restart = rsp_reg.dial_timer_restart;
    assign rsp.mode_committed     = rsp_reg.mode_committed;

endmodule

FILE: src/smms_step.sv
// Next-state and result logic for one line event.
module smms_step (
    input  smms_pkg::cfg_t                cfg,
    input  smms_pkg::state_t              cur,
    input  logic [1:0]                    func,
    input  logic                          level,
    input  logic [smms_pkg::TIME_W-1:0]   now,
    input  logic                          command_level,
    input  logic [smms_pkg::BYTE_W-1:0]   data_byte,
    input  logic [smms_pkg::BIT_W-1:0]    cycles_per_bit,
    output smms_pkg::state_t              nxt,
    output smms_pkg::result_t             res
);
    import smms_pkg::*;

    logic [TIME_W-1:0] gap;
    logic              gap_bad;
    logic [2:0]        phase_base;
    logic [2:0]        phase_inc;
    logic [3:0]        bits_shifted;
    logic              hook_new;
    logic [NUM_WIN-1:0] win_hit;
    logic              win_any;
    logic [1:0]        win_idx;

    // Time the motor edge against the last one
    assign gap     = now - cur.last_edge_time;
    assign gap_bad = (gap < {{(TIME_W-GAP_W){1'b0}}, cfg.edge_gap_min})
                  || (gap > {{(TIME_W-GAP_W){1'b0}}, cfg.edge_gap_max});
    assign phase_base   = gap_bad ? 3'd0 : cur.shift_phase;
    assign phase_inc    = phase_base + 3'd1;
    assign bits_shifted = {~command_level, cur.shift_bits[3:1]};
    assign hook_new     = bits_shifted[1];

    // Match the bit period against the baud windows, first hit wins
    always_comb
    begin
        win_any = 1'b0;
        win_idx = 2'd0;
        for (int k = 0; k < NUM_WIN; k++)
        begin
            win_hit[k] = (cycles_per_bit >= WIN_LO[k]) && (cycles_per_bit <= WIN_HI[k]);
        end
        for (int k = NUM_WIN - 1; k >= 0; k--)
        begin
            if (win_hit[k])
            begin
                win_any = 1'b1;
                win_idx = 2'(k);
            end
        end
    end

    // Apply the event
    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (func)
            FUNC_MOTOR:
            begin
                nxt.last_edge_time = now;
                nxt.shift_phase    = phase_base;
                if (level == ~phase_base[0])
                begin
                    nxt.shift_phase = phase_inc;
                    if (phase_inc[0])
                    begin
                        nxt.shift_bits = bits_shifted;
                        if (phase_inc == PHASE_COMMIT)
                        begin
                            nxt.shift_phase    = 3'd0;
                            res.mode_committed = 1'b1;
                            nxt.comm_flag      = bits_shifted[0];
                            nxt.answer_flag    = bits_shifted[2];
                            nxt.dial_flag      = bits_shifted[3];
                            if (hook_new != cur.hook_flag)
                            begin
                                nxt.hook_flag = hook_new;
                                res.do_answer = hook_new && bits_shifted[2];
                                res.do_hangup = ~hook_new;
                            end
                        end
                    end
                end
            end
            FUNC_COMMAND:
            begin
                res.dial_timer_restart = cur.dial_flag && level;
            end
            FUNC_BYTE:
            begin
                if (cur.comm_flag && (cycles_per_bit >= cfg.min_bit_cycles) && win_any)
                begin
                    nxt.rate_index    = win_idx;
                    res.forward_valid = 1'b1;
                    res.forward_byte  = data_byte;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        res.rate_code   = nxt.rate_index;
        res.comm_active = nxt.comm_flag;
        res.off_hook    = nxt.hook_flag;
        res.answer_mode = nxt.answer_flag;
        res.dial_mode   = nxt.dial_flag;
    end

endmodule

FILE: src/smms_checker.sv
// Port-level checks of the mode shifter and their binding to the top level.
`include "serial_modem_mode_shifter_core_defines.svh"

module smms_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          forward_valid,
    input logic [smms_pkg::BYTE_W-1:0]   forward_byte,
    input logic                          comm_active,
    input logic                          off_hook,
    input logic                          answer_mode,
    input logic                          do_answer,
    input logic                          do_hangup,
    input logic                          mode_committed
);
    import smms_pkg::*;

    // An accepted word yields a result word next cycle
    `SMMS_ASSERT_NEXT(a_accept_to_result, clk, rst_n, req_valid && req_ready, rsp_valid, "accepted word gave no result")

    // A stalled result holds
    `SMMS_ASSERT_NEXT(a_stall_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(forward_byte) && $stable(forward_valid), "stalled result changed")

    // Bytes pass only while comm is active
    `SMMS_ASSERT_SAME(a_fwd_needs_comm, clk, rst_n, rsp_valid && forward_valid, comm_active, "byte forwarded with comm inactive")

    // Answer pulse only on a commit that leaves the line off hook in answer mode
    `SMMS_ASSERT_SAME(a_answer_pulse, clk, rst_n, rsp_valid && do_answer, off_hook && answer_mode && mode_committed && !do_hangup, "bad answer pulse")

    // Hang-up pulse only on a commit that leaves the line on hook
    `SMMS_ASSERT_SAME(a_hangup_pulse, clk, rst_n, rsp_valid && do_hangup, !off_hook && mode_committed, "bad hang-up pulse")

endmodule

bind serial_modem_mode_shifter_core smms_checker u_smms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .forward_valid  (rsp.forward_valid),
    .forward_byte   (rsp.forward_byte),
    .comm_active    (rsp.comm_active),
    .off_hook       (rsp.off_hook),
    .answer_mode    (rsp.answer_mode),
    .do_answer      (rsp.do_answer),
    .do_hangup      (rsp.do_hangup),
    .mode_committed (rsp.mode_committed)
);

FILE: test/serial_modem_mode_shifter_core_test.sv
// Self-checking testbench of the serial modem mode shifter core.
module serial_modem_mode_shifter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smms_pkg::*;

    // Event code that carries no line event
    localparam logic [1:0] FUNC_IDLE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_LIMIT = 200;

    typedef struct packed {
        logic [1:0]        func;
        logic              level;
        logic [TIME_W-1:0] now;
        logic              command_level;
        logic [BYTE_W-1:0] data_byte;
        logic [BIT_W-1:0]  cycles_per_bit;
    } line_event_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    smms_in_if  req_if ();
    smms_out_if rsp_if ();

    serial_modem_mode_shifter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the registers and line state
    cfg_t   model_cfg;
    state_t line_state;

    line_event_t pending_events [$];
    result_t     expected_status [$];
    line_event_t offered;
    logic [TIME_W-1:0] line_clock;

    int  queued_words;
    int  mismatches;
    int  cycle_count;
    int  sender_wait;
    int  receiver_wait;
    int  stall_left;
    int  long_stall;
    bit  sender_gaps;
    bit  receiver_gaps;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abandon a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words outstanding", $time, expected_status.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Advance the shadow state by one line event and return its status word
    function automatic result_t shift_line_event(line_event_t ev);
        result_t r;
        logic [TIME_W-1:0] gap;
        logic hook;
        bit matched;
        r = '0;
        matched = 1'b0;
        case (ev.func)
            FUNC_MOTOR:
            begin
                gap = ev.now - line_state.last_edge_time;
                line_state.last_edge_time = ev.now;
                if (gap < model_cfg.edge_gap_min || gap > model_cfg.edge_gap_max)
                    line_state.shift_phase = '0;
                // even phases wait for an assert, odd phases for a negate
                if (ev.level == ~line_state.shift_phase[0])
                begin
                    line_state.shift_phase = line_state.shift_phase + 3'd1;
                    if (line_state.shift_phase[0])
                    begin
                        line_state.shift_bits = {~ev.command_level, line_state.shift_bits[3:1]};
                        if (line_state.shift_phase == PHASE_COMMIT)
                        begin
                            line_state.shift_phase = '0;
                            r.mode_committed = 1'b1;
                            line_state.comm_flag = line_state.shift_bits[0];
                            line_state.answer_flag = line_state.shift_bits[2];
                            hook = line_state.shift_bits[1];
                            // answer mode is already the new one here
                            if (hook != line_state.hook_flag)
                            begin
                                line_state.hook_flag = hook;
                                if (hook)
                                    r.do_answer = line_state.answer_flag;
                                else
                                    r.do_hangup = 1'b1;
                            end
                            line_state.dial_flag = line_state.shift_bits[3];
                        end
                    end
                end
            end
            FUNC_COMMAND:
                r.dial_timer_restart = line_state.dial_flag & ev.level;
            FUNC_BYTE:
            begin
                if (line_state.comm_flag && ev.cycles_per_bit >= model_cfg.min_bit_cycles)
                begin
                    // first matching baud window wins
                    for (int k = 0; k < NUM_WIN; k++)
                    begin
                        if (!matched && ev.cycles_per_bit >= WIN_LO[k]
                                && ev.cycles_per_bit <= WIN_HI[k])
                        begin
                            matched = 1'b1;
                            line_state.rate_index = 2'(k);
                            r.forward_valid = 1'b1;
                            r.forward_byte = ev.data_byte;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.rate_code = line_state.rate_index;
        r.comm_active = line_state.comm_flag;
        r.off_hook = line_state.hook_flag;
        r.answer_mode = line_state.answer_flag;
        r.dial_mode = line_state.dial_flag;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Offer queued words, with a random pause after each one taken while sender gaps are on
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            sender_wait = 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_status.push_back(shift_line_event(offered));
                sender_wait = sender_gaps ? $urandom_range(0, 3) : 0;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (sender_wait > 0)
                begin
                    sender_wait--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    offered = pending_events.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.func <= offered.func;
                    req_if.level <= offered.level;
                    req_if.now <= offered.now;
                    req_if.command_level <= offered.command_level;
                    req_if.data_byte <= offered.data_byte;
                    req_if.cycles_per_bit <= offered.cycles_per_bit;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Take status words, compare them and stall the output at random
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            receiver_wait = 0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.forward_valid = rsp_if.forward_valid;
                got.forward_byte = rsp_if.forward_byte;
                got.rate_code = rsp_if.rate_code;
                got.comm_active = rsp_if.comm_active;
                got.off_hook = rsp_if.off_hook;
                got.answer_mode = rsp_if.answer_mode;
                got.dial_mode = rsp_if.dial_mode;
                got.do_answer = rsp_if.do_answer;
                got.do_hangup = rsp_if.do_hangup;
                got.dial_timer_restart = rsp_if.dial_timer_restart;
                got.mode_committed = rsp_if.mode_committed;
                if (expected_status.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: status word expected none, got %0h", $time, got);
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("forward_valid", 8'(want.forward_valid),
                                8'(got.forward_valid));
                    check_field("forward_byte", want.forward_byte, got.forward_byte);
                    check_field("rate_code", 8'(want.rate_code), 8'(got.rate_code));
                    check_field("comm_active", 8'(want.comm_active), 8'(got.comm_active));
                    check_field("off_hook", 8'(want.off_hook), 8'(got.off_hook));
                    check_field("answer_mode", 8'(want.answer_mode), 8'(got.answer_mode));
                    check_field("dial_mode", 8'(want.dial_mode), 8'(got.dial_mode));
                    check_field("do_answer", 8'(want.do_answer), 8'(got.do_answer));
                    check_field("do_hangup", 8'(want.do_hangup), 8'(got.do_hangup));
                    check_field("dial_timer_restart", 8'(want.dial_timer_restart),
                                8'(got.dial_timer_restart));
                    check_field("mode_committed", 8'(want.mode_committed),
                                8'(got.mode_committed));
                end
                receiver_wait = receiver_gaps ? $urandom_range(0, 3) : 0;
            end
            if (long_stall > 0)
            begin
                stall_left = long_stall;
                long_stall = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (receiver_wait > 0)
            begin
                receiver_wait--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    function automatic line_event_t random_event();
        line_event_t ev;
        ev.func = 2'($urandom_range(0, 3));
        ev.level = 1'($urandom());
        ev.now = {16'($urandom()), $urandom()};
        ev.command_level = 1'($urandom());
        ev.data_byte = 8'($urandom());
        ev.cycles_per_bit = BIT_W'($urandom());
        return ev;
    endfunction

    function automatic logic [TIME_W-1:0] gap_past_window();
        return TIME_W'(model_cfg.edge_gap_max) + 48'd1 + TIME_W'($urandom_range(0, 1000));
    endfunction

    // Pick a motor edge gap inside the window, or most likely outside it
    function automatic logic [TIME_W-1:0] draw_gap(bit fit);
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        lo = TIME_W'(model_cfg.edge_gap_min);
        hi = TIME_W'(model_cfg.edge_gap_max);
        if (fit && lo <= hi)
        begin
            case ($urandom_range(0, 3))
                0: return lo;
                1: return hi;
                default: return TIME_W'($urandom_range(32'(lo), 32'(hi)));
            endcase
        end
        case ($urandom_range(0, 2))
            0: return (lo > 0) ? lo - 48'd1 : gap_past_window();
            1: return gap_past_window();
            default: return TIME_W'($urandom_range(0, 2000000));
        endcase
    endfunction

    // Bit periods cluster round the baud windows and the rejection threshold
    function automatic logic [BIT_W-1:0] draw_period();
        int k;
        k = $urandom_range(0, NUM_WIN - 1);
        case ($urandom_range(0, 9))
            0: return BIT_W'($urandom());
            1: return $urandom_range(0, 1) ? {BIT_W{1'b1}} : {BIT_W{1'b0}};
            2: return model_cfg.min_bit_cycles + BIT_W'($urandom_range(0, 2)) - 1'b1;
            default: return BIT_W'($urandom_range(WIN_LO[k] - 3, WIN_HI[k] + 3));
        endcase
    endfunction

    function automatic void push_word(line_event_t ev);
        pending_events.push_back(ev);
        queued_words++;
    endfunction

    function automatic void push_edge(logic lvl, logic cmd, logic [TIME_W-1:0] gap);
        line_event_t ev;
        ev = random_event();
        line_clock = line_clock + gap;
        ev.func = FUNC_MOTOR;
        ev.level = lvl;
        ev.command_level = cmd;
        ev.now = line_clock;
        push_word(ev);
    endfunction

    function automatic void push_command(logic lvl);
        line_event_t ev;
        ev = random_event();
        ev.func = FUNC_COMMAND;
        ev.level = lvl;
        ev.now = line_clock;
        push_word(ev);
    endfunction

    function automatic void push_byte(logic [BYTE_W-1:0] data, logic [BIT_W-1:0] period);
        line_event_t ev;
        ev = random_event();
        ev.func = FUNC_BYTE;
        ev.data_byte = data;
        ev.cycles_per_bit = period;
        ev.now = line_clock;
        push_word(ev);
    endfunction

    // Seven alternating motor edges that shift in the inverted mode bits;
    // a broken word goes wrong at one edge, exact words use the window limits
    task automatic push_mode_word(logic [3:0] mode, bit broken, bit exact);
        int cut;
        logic lvl;
        logic [TIME_W-1:0] gap;
        cut = broken ? $urandom_range(0, 6) : 7;
        for (int k = 0; k < 7; k++)
        begin
            lvl = (k % 2 == 0);
            if (k == 0)
                gap = (exact || $urandom_range(0, 3) != 0) ? gap_past_window()
                                                           : draw_gap(1'b1);
            else if (exact)
                gap = (k % 2) ? TIME_W'(model_cfg.edge_gap_min)
                              : TIME_W'(model_cfg.edge_gap_max);
            else
                gap = draw_gap(1'b1);
            if (k == cut)
            begin
                case ($urandom_range(0, 2))
                    0: gap = draw_gap(1'b0);
                    1: lvl = ~lvl;
                    default: return;
                endcase
            end
            push_edge(lvl, (k % 2) ? 1'($urandom()) : ~mode[k / 2], gap);
            // slip in a word that must leave the shift phase alone
            if (!exact && $urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                    push_command(1'($urandom()));
                else
                    push_byte(8'($urandom()), draw_period());
            end
        end
    endtask

    task automatic push_random_words(int count);
        int stop;
        int pick;
        logic [3:0] mode;
        stop = queued_words + count;
        while (queued_words < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                mode = 4'($urandom());
                if ($urandom_range(0, 3) != 0)
                    mode[0] = 1'b1;
                push_mode_word(mode, $urandom_range(0, 6) == 0, 1'b0);
            end
            else if (pick < 75)
                push_byte(8'($urandom()), draw_period());
            else if (pick < 87)
                push_command(1'($urandom()));
            else
                push_word(random_event());
        end
    endtask

    // Hold until every queued word is taken and every status word is back
    task automatic wait_all_taken();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || req_if.valid || expected_status.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_EDGE_GAP_MIN:   model_cfg.edge_gap_min = value;
            CFG_EDGE_GAP_MAX:   model_cfg.edge_gap_max = value;
            CFG_MIN_BIT_CYCLES: model_cfg.min_bit_cycles = value[BIT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic write_all(logic [CFG_DAT_W-1:0] gap_min, logic [CFG_DAT_W-1:0] gap_max,
                             logic [CFG_DAT_W-1:0] bit_min);
        write_reg(CFG_EDGE_GAP_MIN, gap_min);
        write_reg(CFG_EDGE_GAP_MAX, gap_max);
        write_reg(CFG_MIN_BIT_CYCLES, bit_min);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_MOTOR;
        req_if.level = 1'b0;
        req_if.now = '0;
        req_if.command_level = 1'b0;
        req_if.data_byte = '0;
        req_if.cycles_per_bit = '0;
        rsp_if.ready = 1'b0;
        model_cfg = '{EDGE_GAP_MIN_RST, EDGE_GAP_MAX_RST, MIN_BIT_CYCLES_RST};
        line_state = '0;
        queued_words = 0;
        mismatches = 0;
        cycle_count = 0;
        long_stall = 0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words on reset registers; the line clock wraps mid-sequence
        line_clock = '1;
        line_clock = line_clock - 48'd400000;
        begin
            line_event_t ev;
            ev = random_event();
            ev.func = FUNC_IDLE;
            push_word(ev);
        end
        push_byte(8'hA5, 18'd6000);
        push_command(1'b1);
        push_edge(1'b0, 1'b1, 48'd1000);
        push_mode_word(4'b1111, 1'b0, 1'b1);
        push_command(1'b1);
        push_command(1'b0);
        push_byte(8'h00, 18'd5666);
        push_byte(8'hFF, 18'd8950);
        push_byte(8'h5A, 18'd15457);
        push_byte(8'hC3, 18'd3759);
        push_byte(8'h11, 18'd2999);
        push_byte(8'h22, 18'd6266);
        push_mode_word(4'b0000, 1'b0, 1'b1);
        wait_all_taken();

        // Widest windows and no byte threshold
        write_all(20'd0, 20'd1048575, 20'd0);
        push_random_words(500);
        wait_all_taken();

        // Narrow gaps, threshold inside the 300 baud window; long output stall
        write_all(20'd1000, 20'd2000, 20'd5700);
        push_random_words(250);
        @(negedge clk);
        long_stall = 80;
        wait_all_taken();
        push_random_words(200);
        wait_all_taken();

        // Empty window and a threshold that drops every byte, no idling at all
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        write_all(20'd1048575, 20'd0, 20'd262143);
        push_random_words(150);
        wait_all_taken();

        // Window of a single gap value; only the output side idles
        receiver_gaps = 1'b1;
        write_all(20'd20, 20'd20, 20'd3500);
        push_random_words(300);
        wait_all_taken();

        // Back to the reset values; only the input side idles
        sender_gaps = 1'b1;
        receiver_gaps = 1'b0;
        write_all(EDGE_GAP_MIN_RST, EDGE_GAP_MAX_RST, CFG_DAT_W'(MIN_BIT_CYCLES_RST));
        push_random_words(450);
        wait_all_taken();

        if (mismatches == 0 && expected_status.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: serial_modem_mode_shifter_core.f
+incdir+src
src/smms_pkg.sv
src/smms_in_if.sv
src/smms_out_if.sv
src/smms_step.sv
src/serial_modem_mode_shifter_core.sv
src/smms_checker.sv
test/serial_modem_mode_shifter_core_test.sv
